// File: hw/rtl/pitch_class_histogram_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// pitch_class_histogram_tracker_top_assert.svh
// Assertion macros for the pitch class histogram tracker.
// ----------------------------------------------------------------------------
`ifndef PITCH_CLASS_HISTOGRAM_TRACKER_TOP_ASSERT_SVH
`define PITCH_CLASS_HISTOGRAM_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PCHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define PCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pcht_pkg.sv
// ----------------------------------------------------------------------------
// pcht_pkg
// Shared widths, constants and types of the pitch class histogram tracker.
// ----------------------------------------------------------------------------
package pcht_pkg;

	// pitch input: unsigned, 8 fractional bits
	localparam int PITCH_W         = 24;
	localparam int PITCH_FRAC_BITS = 8;

	// mantissa in Q1.23 and fractional log2 resolution
	localparam int MANT_BITS = 23;
	localparam int LOG_BITS  = 16;
	localparam int LOG_CNT_W = $clog2(LOG_BITS);

	// result fields
	localparam int CLASS_W = 5;
	localparam int CONF_W  = 16;
	localparam logic [CONF_W-1:0] CONF_MAX = '1;

	// entries of the queue between classifier and histogram unit
	localparam int QUEUE_DEPTH = 2;

	// fractional log2 of the pitch, handed from front to back
	typedef logic [LOG_BITS-1:0] frac_t;

endpackage

// File: hw/rtl/pitch_class_histogram_tracker_top.sv
// ----------------------------------------------------------------------------
// pitch_class_histogram_tracker_top
// Quarter-tone pitch class tracker with a decaying class histogram.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, pitch_hz              | in
//   output  | out_valid, out_ready, pitch_class,        | out
//           | dominant_class, class_confidence          |
//
// The classifier spends up to 15 normalizing shifts plus 16 squaring steps
// per pitch on one 24x24 multiplier. The histogram unit passes one level per
// cycle through the update lane, then runs 16 steps of the serial divider.
// A two-entry queue between them lets both run at once, so the histogram unit
// sets the sustained rate.
// Reset is asynchronous and clears all levels at once; no clearing pass.
// A stalled output holds the finished result while the next item proceeds.
// ----------------------------------------------------------------------------
`include "pitch_class_histogram_tracker_top_assert.svh"

module pitch_class_histogram_tracker_top #(
	parameter int NUM_CLASSES     = 24,
	parameter int LEVEL_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pcht_pkg::PITCH_W-1:0]  pitch_hz,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcht_pkg::CLASS_W-1:0]  pitch_class,
	output logic [pcht_pkg::CLASS_W-1:0]  dominant_class,
	output logic [pcht_pkg::CONF_W-1:0]   class_confidence
);

	logic            fr_valid;
	logic            fr_ready;
	pcht_pkg::frac_t fr_data;
	logic            bk_valid;
	logic            bk_ready;
	pcht_pkg::frac_t bk_data;
	logic [pcht_pkg::CLASS_W-1:0] chk_up;
	logic [pcht_pkg::CLASS_W-1:0] chk_dn;

	// classifier front end
	pcht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pitch_hz   (pitch_hz),
		.frac_valid (fr_valid),
		.frac_ready (fr_ready),
		.frac       (fr_data)
	);

	// decoupling queue
	pcht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	// histogram unit
	pcht_back #(
		.NUM_CLASSES     (NUM_CLASSES),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.frac_valid       (bk_valid),
		.frac_ready       (bk_ready),
		.frac             (bk_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pitch_class      (pitch_class),
		.dominant_class   (dominant_class),
		.class_confidence (class_confidence)
	);

	// circular neighbours of the reported class, for checking
	always_comb begin
		chk_up = (pitch_class == pcht_pkg::CLASS_W'(NUM_CLASSES - 1)) ? '0 :
			pitch_class + 1'b1;
		chk_dn = (pitch_class == '0) ? pcht_pkg::CLASS_W'(NUM_CLASSES - 1) :
			pitch_class - 1'b1;
	end

	`PCHT_ASSERT_IMPL(a_class_range, clk, arst_n,
		out_valid && (NUM_CLASSES <= 32),
		(32'(pitch_class) < NUM_CLASSES) && (32'(dominant_class) < NUM_CLASSES),
		"class out of range")
	`PCHT_ASSERT_IMPL(a_conf_adjacent, clk, arst_n,
		out_valid && (class_confidence != '0) && (NUM_CLASSES <= 32),
		(dominant_class == pitch_class) || (dominant_class == chk_up) ||
		(dominant_class == chk_dn),
		"confidence given for a dominant class that is not adjacent")
	`PCHT_ASSERT_NEXT(a_front_busy, clk, arst_n,
		in_valid && in_ready,
		!in_ready,
		"classifier took a second pitch straight after a transfer")

endmodule

// File: hw/rtl/pcht_front.sv
// ----------------------------------------------------------------------------
// pcht_front
// Classifier front end: normalizes the pitch bit by bit, then finds the
// fractional log2 by repeated squaring, one bit per cycle.
// ----------------------------------------------------------------------------
module pcht_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pcht_pkg::PITCH_W-1:0]  pitch_hz,
	output logic                          frac_valid,
	input  logic                          frac_ready,
	output pcht_pkg::frac_t               frac
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_LOG  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int XW = pcht_pkg::MANT_BITS + 1;

	logic [1:0]                       state_q;
	logic [XW-1:0]                    x_q;
	pcht_pkg::frac_t                  f_q;
	logic [pcht_pkg::LOG_CNT_W-1:0]   cnt_q;
	logic [2*XW-1:0]                  sq;
	logic [XW:0]                      sq_shr;
	logic                             f_bit;
	logic                             low_pitch;

	// square the mantissa and rescale to Q2.23
	always_comb begin
		sq        = x_q * x_q;
		sq_shr    = sq[2*XW-1:pcht_pkg::MANT_BITS];
		f_bit     = sq_shr[XW];
		low_pitch = (pitch_hz[pcht_pkg::PITCH_W-1:pcht_pkg::PITCH_FRAC_BITS] == '0);
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign frac_valid = (state_q == ST_DONE);
	assign frac       = f_q;

	// sequence: take item, normalize, square, hand over (a pitch below 1 Hz skips straight to hand over)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= low_pitch ? ST_DONE : ST_NORM;
					end
				end
				ST_NORM: begin
					if (x_q[XW-1]) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (frac_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: mantissa, log bits and step count
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= XW'(pitch_hz);
				f_q <= '0;
			end
			ST_NORM: begin
				cnt_q <= pcht_pkg::LOG_CNT_W'(pcht_pkg::LOG_BITS - 1);
				if (!x_q[XW-1]) begin
					x_q <= {x_q[XW-2:0], 1'b0};
				end
			end
			ST_LOG: begin
				cnt_q <= cnt_q - 1'b1;
				f_q   <= {f_q[pcht_pkg::LOG_BITS-2:0], f_bit};
				x_q   <= f_bit ? sq_shr[XW:1] : sq_shr[XW-1:0];
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

endmodule

// File: hw/rtl/pcht_queue.sv
// ----------------------------------------------------------------------------
// pcht_queue
// Short first-in first-out queue that decouples the classifier from the
// histogram unit.
// ----------------------------------------------------------------------------
module pcht_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pcht_pkg::frac_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output pcht_pkg::frac_t pop_data
);

	localparam int AW = $clog2(pcht_pkg::QUEUE_DEPTH);

	pcht_pkg::frac_t mem_q [pcht_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != (AW+1)'(pcht_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// store entry on transfer in
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/pcht_back.sv
// ----------------------------------------------------------------------------
// pcht_back
// Histogram unit: maps the log fraction to a class, rotates the level bank
// through one update lane, tracks maximum and sum, then divides serially.
// ----------------------------------------------------------------------------
module pcht_back #(
	parameter int NUM_CLASSES     = 24,
	parameter int LEVEL_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frac_valid,
	output logic                          frac_ready,
	input  pcht_pkg::frac_t               frac,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcht_pkg::CLASS_W-1:0]  pitch_class,
	output logic [pcht_pkg::CLASS_W-1:0]  dominant_class,
	output logic [pcht_pkg::CONF_W-1:0]   class_confidence
);

	localparam logic [2:0] ST_WAIT  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DINIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam int CW    = $clog2(NUM_CLASSES);
	localparam int PW    = CW + pcht_pkg::LOG_BITS;
	localparam int LW    = LEVEL_FRAC_BITS + 2;
	localparam int SW    = LW + CW;
	localparam int DCW   = $clog2(pcht_pkg::CONF_W);
	localparam logic [CW-1:0] LAST   = CW'(NUM_CLASSES - 1);
	localparam logic [LW-1:0] LV_ONE  = LW'(1) << LEVEL_FRAC_BITS;
	localparam logic [LW-1:0] LV_HALF = LV_ONE >> 1;
	localparam logic [LW-1:0] LV_TOP  = LV_ONE << 1;

	logic [2:0]                    state_q;
	logic [LW-1:0]                 lv_q [NUM_CLASSES];
	logic [CW-1:0]                 cls_q;
	logic [CW-1:0]                 up_q;
	logic [CW-1:0]                 dn_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 dom_q;
	logic [LW-1:0]                 max_q;
	logic [SW-1:0]                 sum_q;
	logic [SW-1:0]                 rem_q;
	logic [pcht_pkg::CONF_W-1:0]   quo_q;
	logic [DCW-1:0]                cnt_q;
	logic                          sat_q;
	logic                          out_valid_q;
	logic [pcht_pkg::CLASS_W-1:0]  pitch_class_q;
	logic [pcht_pkg::CLASS_W-1:0]  dominant_class_q;
	logic [pcht_pkg::CONF_W-1:0]   conf_q;

	logic [PW-1:0]   prod;
	logic [CW-1:0]   cls_raw;
	logic [CW-1:0]   cls_new;
	logic [LW-1:0]   lv_add;
	logic [LW-1:0]   lv_sum;
	logic [LW-1:0]   lv_upd;
	logic [SW:0]     rem_sh;
	logic            quo_bit;
	logic            adjacent;
	logic            out_free;

	// class from log fraction, bounded to the last class
	always_comb begin
		prod    = PW'(NUM_CLASSES) * PW'(frac);
		cls_raw = prod[PW-1:pcht_pkg::LOG_BITS];
		cls_new = (cls_raw > LAST) ? LAST : cls_raw;
	end

	// update lane: halve head level, add bump, clamp
	always_comb begin
		if (idx_q == cls_q) begin
			lv_add = LV_ONE;
		end else if (idx_q == up_q || idx_q == dn_q) begin
			lv_add = LV_HALF;
		end else begin
			lv_add = '0;
		end
		lv_sum = {1'b0, lv_q[0][LW-1:1]} + lv_add;
		lv_upd = (lv_sum > LV_TOP) ? LV_TOP : lv_sum;
	end

	// restoring divide step
	always_comb begin
		rem_sh  = {rem_q, 1'b0};
		quo_bit = (rem_sh >= {1'b0, sum_q});
	end

	assign adjacent   = (dom_q == cls_q) || (dom_q == up_q) || (dom_q == dn_q);
	assign out_free   = !out_valid_q || out_ready;
	assign frac_ready = (state_q == ST_WAIT);

	assign out_valid        = out_valid_q;
	assign pitch_class      = pitch_class_q;
	assign dominant_class   = dominant_class_q;
	assign class_confidence = conf_q;

	// control sequence and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result on transfer out, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_WAIT: begin
					if (frac_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q == LAST) begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_WAIT;
					end
				end
				default: begin
					state_q <= ST_WAIT;
				end
			endcase
		end
	end

	// level bank: rotate through the update lane during the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				lv_q[k] <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			for (int k = 0; k < NUM_CLASSES - 1; k++) begin
				lv_q[k] <= lv_q[k+1];
			end
			lv_q[NUM_CLASSES-1] <= lv_upd;
		end
	end

	// datapath: class, scan statistics, divider and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_WAIT: begin
				cls_q <= cls_new;
			end
			ST_PREP: begin
				up_q  <= (cls_q == LAST) ? '0 : cls_q + 1'b1;
				dn_q  <= (cls_q == '0) ? LAST : cls_q - 1'b1;
				idx_q <= '0;
				sum_q <= '0;
			end
			ST_SCAN: begin
				idx_q <= idx_q + 1'b1;
				sum_q <= sum_q + SW'(lv_upd);
				if (idx_q == '0 || lv_upd > max_q) begin
					max_q <= lv_upd;
					dom_q <= idx_q;
				end
			end
			ST_DINIT: begin
				rem_q <= SW'(max_q);
				quo_q <= '0;
				cnt_q <= DCW'(pcht_pkg::CONF_W - 1);
				sat_q <= (SW'(max_q) == sum_q);
			end
			ST_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				quo_q <= {quo_q[pcht_pkg::CONF_W-2:0], quo_bit};
				rem_q <= quo_bit ? SW'(rem_sh - {1'b0, sum_q}) : SW'(rem_sh);
			end
			ST_FIN: begin
				if (out_free) begin
					pitch_class_q    <= pcht_pkg::CLASS_W'(cls_q);
					dominant_class_q <= pcht_pkg::CLASS_W'(dom_q);
					if (!adjacent) begin
						conf_q <= '0;
					end else if (sat_q) begin
						conf_q <= pcht_pkg::CONF_MAX;
					end else begin
						conf_q <= quo_q;
					end
				end
			end
			default: begin
				cls_q <= cls_q;
			end
		endcase
	end

endmodule
